// ----- rtl/core/hsvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, the hue sector type and the control word of the channel
// scaler.
// ----------------------------------------------------------------------------
package hsvc_pkg;

  localparam logic [8:0] HUE_MAX = 9'd359;
  localparam logic [6:0] PCT_MAX = 7'd100;

  // Channel level is floor(255 * k / 600000) = floor(floor(17 * k / 64) / 625).
  localparam int          LEVEL_W     = 20;
  localparam int          SCALED_W    = 24;
  localparam int          PRE_SHIFT   = 6;
  // Reciprocal of 625 at 28 fractional bits, exact for quotients below 2^18.
  localparam int          RECIP_SHIFT = 28;
  localparam logic [18:0] RECIP       = 19'd429497;
  localparam int          QUOT_W      = SCALED_W - PRE_SHIFT;
  localparam int          PROD_W      = QUOT_W + 19;
  localparam logic [LEVEL_W-1:0] DENOM = 20'd600000;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } hsvc_sector_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_quo;
  } hsvc_lvl_ctl_t;

endpackage

// ----- rtl/core/hsvc_level.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Channel level scaler
// Two register stages that turn a numerator over 600000 into an 8-bit level.
// ----------------------------------------------------------------------------
module hsvc_level
  import hsvc_pkg::*;
(
  input  logic                clk,
  input  hsvc_lvl_ctl_t       ctl,
  input  logic [LEVEL_W-1:0]  num,
  output logic [7:0]          level
);

  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] scaled_next;
  logic [QUOT_W-1:0]   quot;
  logic [PROD_W-1:0]   prod;

  // Multiply by 17 as a shift and an add.
  assign scaled_next = (SCALED_W'(num) << 4) + SCALED_W'(num);
  assign quot        = scaled[SCALED_W-1:PRE_SHIFT];
  assign prod        = PROD_W'(quot) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      scaled <= scaled_next;
    end
    if (ctl.ld_quo) begin
      level <= prod[RECIP_SHIFT +: 8];
    end
  end

endmodule

// ----- rtl/core/hsv_to_rgb_converter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline that turns one HSV word into one 8-bit RGB word.
// ----------------------------------------------------------------------------
// The block takes one word per clock while the output is not stalled and
// returns one RGB word for each HSV word, in order. Hue is in degrees and
// saturates at 359; saturation and brightness are in percent and saturate
// at 100. The six register stages are: clamp and sector decode, the two 7x7
// products, chroma and secondary component, channel selection, the multiply
// by 17, and the reciprocal multiply that divides by 625. Each stage holds
// its word while the stage after it is full and stalled, so in_ready drops
// only when all six stages hold a word and out_ready is low. The enable
// register is sampled when a word is accepted; a word taken while enable is
// clear comes out as black. The enable register should be written only while
// no word is in the pipeline.
module hsv_to_rgb_converter_unit
  import hsvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] hue,
  input  logic [6:0] saturation,
  input  logic [6:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);

  logic       enable;
  logic [6:1] vld;
  logic [7:1] adv;

  // Advance chain: a stage loads when it is empty or the next one moves on.
  always_comb begin
    adv[7] = out_ready;
    for (int i = 1; i <= 6; i++) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      vld    <= '0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int i = 2; i <= 6; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: saturate the inputs, find the 60-degree sector and the distance
  // weight w = 60 - |(h mod 120) - 60|, which runs 0..60.
  logic [8:0]   hue_sat;
  logic [6:0]   sat_sat;
  logic [6:0]   bri_sat;
  hsvc_sector_t sector_next;
  logic [8:0]   base;
  logic [8:0]   t;
  logic [5:0]   w_next;

  assign hue_sat = (hue > HUE_MAX) ? HUE_MAX : hue;
  assign sat_sat = (saturation > PCT_MAX) ? PCT_MAX : saturation;
  assign bri_sat = (brightness > PCT_MAX) ? PCT_MAX : brightness;

  always_comb begin
    priority if (hue_sat < 9'd60) begin
      sector_next = SEC_RY;
    end else if (hue_sat < 9'd120) begin
      sector_next = SEC_YG;
    end else if (hue_sat < 9'd180) begin
      sector_next = SEC_GC;
    end else if (hue_sat < 9'd240) begin
      sector_next = SEC_CB;
    end else if (hue_sat < 9'd300) begin
      sector_next = SEC_BM;
    end else begin
      sector_next = SEC_MR;
    end
    priority if (hue_sat < 9'd120) begin
      base = 9'd0;
    end else if (hue_sat < 9'd240) begin
      base = 9'd120;
    end else begin
      base = 9'd240;
    end
    t = hue_sat - base;
    if (t < 9'd60) begin
      w_next = t[5:0];
    end else begin
      w_next = 6'(9'd120 - t);
    end
  end

  logic [6:0]   sat1;
  logic [6:0]   bri1;
  logic [5:0]   w1;
  hsvc_sector_t sector1;
  logic         en1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sat1    <= sat_sat;
      bri1    <= bri_sat;
      w1      <= w_next;
      sector1 <= sector_next;
      en1     <= enable;
    end
  end

  // Stage 2: s*v and v*(100-s), both at most 10000.
  logic [13:0]  sv2;
  logic [13:0]  vms2;
  logic [5:0]   w2;
  hsvc_sector_t sector2;
  logic         en2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sv2     <= 14'(sat1) * 14'(bri1);
      vms2    <= 14'(bri1) * 14'(PCT_MAX - sat1);
      w2      <= w1;
      sector2 <= sector1;
      en2     <= en1;
    end
  end

  // Stage 3: chroma, secondary component and offset over 600000.
  logic [LEVEL_W-1:0] c3;
  logic [LEVEL_W-1:0] x3;
  logic [LEVEL_W-1:0] m3;
  hsvc_sector_t       sector3;
  logic               en3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      c3      <= LEVEL_W'(sv2) * LEVEL_W'(60);
      x3      <= LEVEL_W'(sv2) * LEVEL_W'(w2);
      m3      <= LEVEL_W'(vms2) * LEVEL_W'(60);
      sector3 <= sector2;
      en3     <= en2;
    end
  end

  // Stage 4: the sector routes chroma and the secondary component to the
  // channels. A disabled word carries zero numerators, which scale to zero.
  logic [LEVEL_W-1:0] r_comp;
  logic [LEVEL_W-1:0] g_comp;
  logic [LEVEL_W-1:0] b_comp;
  logic [LEVEL_W-1:0] r4;
  logic [LEVEL_W-1:0] g4;
  logic [LEVEL_W-1:0] b4;

  always_comb begin
    unique case (sector3)
      SEC_RY: begin
        r_comp = c3; g_comp = x3; b_comp = '0;
      end
      SEC_YG: begin
        r_comp = x3; g_comp = c3; b_comp = '0;
      end
      SEC_GC: begin
        r_comp = '0; g_comp = c3; b_comp = x3;
      end
      SEC_CB: begin
        r_comp = '0; g_comp = x3; b_comp = c3;
      end
      SEC_BM: begin
        r_comp = x3; g_comp = '0; b_comp = c3;
      end
      default: begin
        r_comp = c3; g_comp = '0; b_comp = x3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      r4 <= en3 ? r_comp + m3 : '0;
      g4 <= en3 ? g_comp + m3 : '0;
      b4 <= en3 ? b_comp + m3 : '0;
    end
  end

  // Stages 5 and 6: scale each numerator to a level.
  hsvc_lvl_ctl_t lvl_ctl;

  assign lvl_ctl.ld_mul = adv[5];
  assign lvl_ctl.ld_quo = adv[6];

  hsvc_level u_level_r (
    .clk   (clk),
    .ctl   (lvl_ctl),
    .num   (r4),
    .level (red)
  );

  hsvc_level u_level_g (
    .clk   (clk),
    .ctl   (lvl_ctl),
    .num   (g4),
    .level (green)
  );

  hsvc_level u_level_b (
    .clk   (clk),
    .ctl   (lvl_ctl),
    .num   (b4),
    .level (blue)
  );

  // The weight never exceeds 60 and the sector decode stays in range.
  a_weight_range : assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (w1 <= 6'd60 && sector1 <= SEC_MR))
    else $error("hue weight or sector out of range");

  // Numerators never exceed the common denominator, so levels cannot wrap.
  a_num_range : assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (r4 <= DENOM && g4 <= DENOM && b4 <= DENOM))
    else $error("channel numerator above full scale");

  // Input back-pressure only when every stage holds a word.
  a_full_stall : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&vld && !out_ready))
    else $error("input stalled with a free pipeline stage");

  // A word held at the output must not be replaced.
  a_hold_out : assert property (@(posedge clk) disable iff (rst)
    (vld[6] && !out_ready) |=> (vld[6] && $stable(red) && $stable(green)
      && $stable(blue)))
    else $error("stalled output word changed");

endmodule

// ----- bench/tb_hsv_to_rgb_converter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives HSV words through the converter with random gaps on both sides and
// checks every RGB word against an exact integer color model.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_unit;
  import hsvc_pkg::*;

  // Values of the enable register.
  localparam logic ENABLE_OFF = 1'b0;
  localparam logic ENABLE_ON  = 1'b1;

  // Percent chance that a side idles in a given cycle, outside steady stretches.
  localparam int unsigned IDLE_PCT = 25;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles allowed for the pipeline to settle; the block has six stages.
  localparam int unsigned SETTLE_CYCLES = 12;
  // Mismatch lines beyond this count are counted but not printed.
  localparam int unsigned PRINT_LIMIT = 60;

  typedef struct {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsv_word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [8:0] hue = '0;
  logic [6:0] saturation = '0;
  logic [6:0] brightness = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  // Testbench copy of the enable register, used to predict each word.
  logic enable_shadow = ENABLE_OFF;
  // When set, neither side idles.
  logic steady = 1'b0;

  hsv_word_t   pending_hsv[$];
  rgb_word_t   expected_rgb[$];
  hsv_word_t   next_hsv;
  rgb_word_t   seen_rgb;
  rgb_word_t   want_rgb;

  int unsigned error_count = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned words_black = 0;
  int unsigned quiet_cycles = 0;

  hsv_to_rgb_converter_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scales a numerator in units of 1/600000 to an 8-bit level, rounding down.
  function automatic logic [7:0] scale_level(input int unsigned num);
    int unsigned lvl;
    lvl = (num * 255) / int'(DENOM);
    return (lvl > 255) ? 8'd255 : lvl[7:0];
  endfunction

  // Exact integer HSV to RGB conversion. All terms are kept over a common
  // denominator of 600000 so the floor of each channel is exact.
  function automatic rgb_word_t convert_hsv(input hsv_word_t w, input logic en);
    rgb_word_t    o;
    int unsigned  h, s, v, t, span_off, c, x, m, r, g, b;
    hsvc_sector_t sec;
    o.red   = 8'd0;
    o.green = 8'd0;
    o.blue  = 8'd0;
    if (en == ENABLE_OFF) return o;
    // Out-of-range inputs saturate rather than wrap.
    h = (w.hue > HUE_MAX) ? HUE_MAX : w.hue;
    s = (w.saturation > PCT_MAX) ? PCT_MAX : w.saturation;
    v = (w.brightness > PCT_MAX) ? PCT_MAX : w.brightness;
    // Distance from the middle of the current 120-degree span gives the
    // secondary component as a triangle wave.
    t        = h % 120;
    span_off = (t >= 60) ? (t - 60) : (60 - t);
    c        = 60 * s * v;
    x        = s * v * (60 - span_off);
    m        = 60 * v * (PCT_MAX - s);
    sec      = hsvc_sector_t'(h / 60);
    case (sec)
      SEC_RY: begin r = c; g = x; b = 0; end
      SEC_YG: begin r = x; g = c; b = 0; end
      SEC_GC: begin r = 0; g = c; b = x; end
      SEC_CB: begin r = 0; g = x; b = c; end
      SEC_BM: begin r = x; g = 0; b = c; end
      default: begin r = c; g = 0; b = x; end
    endcase
    o.red   = scale_level(r + m);
    o.green = scale_level(g + m);
    o.blue  = scale_level(b + m);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_LIMIT)
      $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Sender: takes the next word from the pending queue, idling at random, and
  // records the predicted RGB word once the converter accepts it.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rgb.push_back(convert_hsv('{hue, saturation, brightness}, enable_shadow));
        words_in++;
        if (enable_shadow == ENABLE_OFF) words_black++;
      end
      // A new word may be presented only when the current one is gone.
      if (!in_valid || in_ready) begin
        if (pending_hsv.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          next_hsv   = pending_hsv.pop_front();
          in_valid   <= 1'b1;
          hue        <= next_hsv.hue;
          saturation <= next_hsv.saturation;
          brightness <= next_hsv.brightness;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares every accepted RGB word with the oldest prediction and
  // stalls the output at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_rgb = '{red, green, blue};
        words_out++;
        if (expected_rgb.size() == 0) begin
          report_mismatch("unexpected word, red", seen_rgb.red, 0);
        end else begin
          want_rgb = expected_rgb.pop_front();
          if (seen_rgb.red !== want_rgb.red)
            report_mismatch("red", seen_rgb.red, want_rgb.red);
          if (seen_rgb.green !== want_rgb.green)
            report_mismatch("green", seen_rgb.green, want_rgb.green);
          if (seen_rgb.blue !== want_rgb.blue)
            report_mismatch("blue", seen_rgb.blue, want_rgb.blue);
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a long run of cycles with no handshake on either side means the
  // converter has hung.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_word(input int h, input int s, input int v);
    hsv_word_t w;
    w.hue        = h[8:0];
    w.saturation = s[6:0];
    w.brightness = v[6:0];
    pending_hsv.push_back(w);
  endtask

  // Most random words stay in range; some sit on sector edges and some use
  // the full field width so the saturation logic is hit too.
  task automatic queue_random_words(input int count);
    int h, s, v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       h = $urandom_range(5) * 60 + ($urandom_range(1) ? 59 : 0);
        1, 2:    h = $urandom_range(511);
        default: h = $urandom_range(359);
      endcase
      s = ($urandom_range(9) < 3) ? $urandom_range(127) : $urandom_range(100);
      v = ($urandom_range(9) < 3) ? $urandom_range(127) : $urandom_range(100);
      queue_word(h, s, v);
    end
  endtask

  // Holds off until every queued word has been converted and checked, then
  // lets the pipeline settle. This is also the point where the sender pauses.
  task automatic drain_pipeline;
    wait (pending_hsv.size() == 0 && expected_rgb.size() == 0 && !in_valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    enable_shadow <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Straight out of reset the enable register is clear, so every word
    // should come out black no matter what color it carries.
    @(negedge clk);
    queue_word(0, 100, 100);
    queue_word(120, 100, 100);
    queue_word(511, 127, 127);
    queue_word(200, 50, 75);
    drain_pipeline();

    // Directed words: every sector edge, the hue clamp, and the percent
    // clamps at their extremes.
    write_enable(ENABLE_ON);
    @(negedge clk);
    queue_word(0, 100, 100);
    queue_word(59, 100, 100);
    queue_word(60, 100, 100);
    queue_word(119, 100, 100);
    queue_word(120, 100, 100);
    queue_word(179, 100, 100);
    queue_word(180, 100, 100);
    queue_word(239, 100, 100);
    queue_word(240, 100, 100);
    queue_word(299, 100, 100);
    queue_word(300, 100, 100);
    queue_word(359, 100, 100);
    queue_word(360, 100, 100);
    queue_word(511, 100, 100);
    queue_word(90, 0, 100);
    queue_word(90, 0, 0);
    queue_word(90, 100, 0);
    queue_word(30, 101, 100);
    queue_word(30, 127, 127);
    queue_word(330, 50, 101);
    queue_word(45, 1, 1);
    queue_word(256, 64, 64);
    queue_word(170, 85, 42);
    drain_pipeline();

    // Random words with idling on both sides.
    @(negedge clk);
    queue_random_words(230);
    drain_pipeline();

    // Clearing enable again must force black output.
    write_enable(ENABLE_OFF);
    @(negedge clk);
    queue_random_words(40);
    drain_pipeline();

    // Back-to-back words with no idling, then more random traffic.
    write_enable(ENABLE_ON);
    @(negedge clk);
    steady <= 1'b1;
    queue_random_words(150);
    drain_pipeline();
    @(negedge clk);
    steady <= 1'b0;
    queue_random_words(110);
    drain_pipeline();

    $display("Converted %0d HSV words (%0d with enable clear) and checked %0d RGB words,",
             words_in, words_black, words_out);
    $display("covering all six hue sectors, the clamps, and gap-free and stalled traffic.");
    if (error_count == 0 && expected_rgb.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
